/* src/fsfe_pkg.sv */
// Shared types, codes and pixel arithmetic for the fading scope frame engine.
package fsfe_pkg;

    localparam int PIX_W = 24;
    localparam logic [PIX_W-1:0] PIX_MASK     = 24'hFCFCFC;
    localparam logic [PIX_W-1:0] RESET_COLOUR = 24'hFF3F7F;

    localparam logic [1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [1:0] FUNC_SAMPLE = 2'd1;
    localparam logic [1:0] FUNC_READ   = 2'd2;
    localparam logic [1:0] FUNC_NONE   = 2'd3;

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_READ  = 7'b0000100,
        ST_BLUR  = 7'b0001000,
        ST_FLUSH = 7'b0010000,
        ST_COL   = 7'b0100000,
        ST_LINE  = 7'b1000000
    } state_t;

    typedef enum logic [2:0] {
        PH_UP    = 3'b001,
        PH_RIGHT = 3'b010,
        PH_DOWN  = 3'b100
    } phase_t;

    typedef struct packed {
        logic load;
        logic hit;
    } rsp_t;

    function automatic logic [PIX_W-1:0] blur_pix(input logic [PIX_W-1:0] up,
                                                  input logic [PIX_W-1:0] left,
                                                  input logic [PIX_W-1:0] right,
                                                  input logic [PIX_W-1:0] down);
        logic [PIX_W+1:0] sum;
        sum = {2'b00, up & PIX_MASK} + {2'b00, left & PIX_MASK}
            + {2'b00, right & PIX_MASK} + {2'b00, down & PIX_MASK};
        return sum[PIX_W+1:2];
    endfunction

endpackage

/* src/fsfe_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
module fsfe_ram #(
    parameter int DATA_W = 24,
    parameter int DEPTH  = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);
    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

/* src/fsfe_ctrl.sv */
// Sequencer: clear sweep, in-place blur, trace drawing and pixel reads on the frame RAM.
module fsfe_ctrl #(
    parameter int WIDTH             = 64,
    parameter int HEIGHT            = 32,
    parameter int SAMPLES_PER_FRAME = 512
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [1:0]                           s_func,
    input  logic signed [15:0]                   s_sample,
    input  logic [5:0]                           s_read_col,
    input  logic [4:0]                           s_read_row,
    input  logic [fsfe_pkg::PIX_W-1:0]           draw_colour,
    input  logic                                 out_free,
    output fsfe_pkg::rsp_t                       rsp,
    output logic                                 ram_we,
    output logic [$clog2(WIDTH*HEIGHT)-1:0]      ram_waddr,
    output logic [fsfe_pkg::PIX_W-1:0]           ram_wdata,
    output logic                                 ram_re,
    output logic [$clog2(WIDTH*HEIGHT)-1:0]      ram_raddr,
    input  logic [fsfe_pkg::PIX_W-1:0]           ram_rdata
);
    import fsfe_pkg::*;

    localparam int NPIX  = WIDTH * HEIGHT;
    localparam int AW    = $clog2(NPIX);
    localparam int CW    = $clog2(WIDTH);
    localparam int RW    = $clog2(HEIGHT);
    localparam int PW    = $clog2(SAMPLES_PER_FRAME);
    localparam int NCW   = $clog2(WIDTH + 1);
    localparam int PRODW = $clog2(WIDTH * SAMPLES_PER_FRAME) + 1;
    localparam int RPW   = 16 + $clog2(HEIGHT + 1);
    localparam int QW    = RPW - 15;

    state_t           state_reg, state_next;
    phase_t           phase_reg, phase_next;
    logic [AW-1:0]    addr_reg, addr_next;
    logic [RW-1:0]    b_row_reg, b_row_next;
    logic [CW-1:0]    b_col_reg, b_col_next;
    logic             pend_reg, pend_next;
    logic [AW-1:0]    wr_addr_reg, wr_addr_next;
    logic [PIX_W-1:0] up_reg, up_next;
    logic [PIX_W-1:0] right_reg, right_next;
    logic [PIX_W-1:0] left_reg, left_next;
    logic             lok_reg, lok_next;
    logic             ok_reg, ok_next;
    logic             rd_ok_reg, rd_ok_next;
    logic [PW-1:0]    pos_reg, pos_next;
    logic [NCW-1:0]   next_col_reg, next_col_next;
    logic [RW-1:0]    prev_row_reg, prev_row_next;
    logic [RW-1:0]    row_reg, row_next;
    logic [RW-1:0]    line_row_reg, line_row_next;
    logic [RW-1:0]    end_row_reg, end_row_next;

    logic             accept;
    logic             in_rng;
    logic [16:0]      shifted;
    logic [RPW-1:0]   row_prod;
    logic [QW-1:0]    row_q;
    logic [RW-1:0]    sample_row;
    logic [PIX_W-1:0] down_v;
    logic [PIX_W-1:0] blur_v;
    logic [RW-1:0]    eff_prev;
    logic [PRODW-1:0] col_lim;
    logic [PRODW-1:0] pos_lim;
    logic             col_go;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign in_rng  = (int'(s_read_col) < WIDTH) && (int'(s_read_row) < HEIGHT);

    assign shifted  = {s_sample[15], s_sample} + 17'sd16384;
    assign row_prod = RPW'(shifted[15:0]) * RPW'(HEIGHT);
    assign row_q    = row_prod[RPW-1:15];

    always_comb begin
        if (shifted[16]) begin
            sample_row = '0;
        end else if (int'(row_q) > HEIGHT - 1) begin
            sample_row = RW'(HEIGHT - 1);
        end else begin
            sample_row = row_q[RW-1:0];
        end
    end

    assign down_v   = ok_reg ? ram_rdata : '0;
    assign blur_v   = blur_pix(up_reg, lok_reg ? left_reg : '0, right_reg, down_v);
    assign eff_prev = (next_col_reg == '0) ? row_reg : prev_row_reg;
    assign col_lim  = PRODW'(next_col_reg) * PRODW'(SAMPLES_PER_FRAME);
    assign pos_lim  = (PRODW'(pos_reg) + PRODW'(1)) * PRODW'(WIDTH);
    assign col_go   = (int'(next_col_reg) < WIDTH) && (col_lim < pos_lim);

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        addr_next     = addr_reg;
        b_row_next    = b_row_reg;
        b_col_next    = b_col_reg;
        pend_next     = pend_reg;
        wr_addr_next  = wr_addr_reg;
        up_next       = up_reg;
        right_next    = right_reg;
        left_next     = left_reg;
        lok_next      = lok_reg;
        ok_next       = ok_reg;
        rd_ok_next    = rd_ok_reg;
        pos_next      = pos_reg;
        next_col_next = next_col_reg;
        prev_row_next = prev_row_reg;
        row_next      = row_reg;
        line_row_next = line_row_reg;
        end_row_next  = end_row_reg;
        rsp           = '0;
        ram_we        = 1'b0;
        ram_waddr     = addr_reg;
        ram_wdata     = '0;
        ram_re        = 1'b0;
        ram_raddr     = addr_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                ram_we = 1'b1;
                if (addr_reg == AW'(NPIX - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    addr_next = addr_reg + AW'(1);
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (s_func)
                        FUNC_CLEAR: begin
                            addr_next  = '0;
                            state_next = ST_CLEAR;
                        end
                        FUNC_SAMPLE: begin
                            row_next = sample_row;
                            if (pos_reg == '0) begin
                                addr_next  = '0;
                                b_row_next = '0;
                                b_col_next = '0;
                                phase_next = PH_UP;
                                pend_next  = 1'b0;
                                state_next = ST_BLUR;
                            end else begin
                                state_next = ST_COL;
                            end
                        end
                        FUNC_READ: begin
                            ram_re     = in_rng;
                            ram_raddr  = AW'(s_read_row) * AW'(WIDTH) + AW'(s_read_col);
                            rd_ok_next = in_rng;
                            state_next = ST_READ;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_READ: begin
                if (out_free) begin
                    rsp.load   = 1'b1;
                    rsp.hit    = rd_ok_reg;
                    state_next = ST_IDLE;
                end
            end
            ST_BLUR: begin
                unique case (phase_reg)
                    PH_UP: begin
                        if (pend_reg) begin
                            ram_we    = 1'b1;
                            ram_waddr = wr_addr_reg;
                            ram_wdata = blur_v;
                            left_next = blur_v;
                        end
                        lok_next   = (b_col_reg != '0);
                        ram_re     = (b_row_reg != '0);
                        ram_raddr  = addr_reg - AW'(WIDTH);
                        ok_next    = (b_row_reg != '0);
                        phase_next = PH_RIGHT;
                    end
                    PH_RIGHT: begin
                        up_next    = down_v;
                        ram_re     = (b_col_reg != CW'(WIDTH - 1));
                        ram_raddr  = addr_reg + AW'(1);
                        ok_next    = (b_col_reg != CW'(WIDTH - 1));
                        phase_next = PH_DOWN;
                    end
                    PH_DOWN: begin
                        right_next   = down_v;
                        ram_re       = (b_row_reg != RW'(HEIGHT - 1));
                        ram_raddr    = addr_reg + AW'(WIDTH);
                        ok_next      = (b_row_reg != RW'(HEIGHT - 1));
                        pend_next    = 1'b1;
                        wr_addr_next = addr_reg;
                        phase_next   = PH_UP;
                        addr_next    = addr_reg + AW'(1);
                        if (b_col_reg == CW'(WIDTH - 1)) begin
                            b_col_next = '0;
                            b_row_next = b_row_reg + RW'(1);
                            if (b_row_reg == RW'(HEIGHT - 1)) begin
                                state_next = ST_FLUSH;
                            end
                        end else begin
                            b_col_next = b_col_reg + CW'(1);
                        end
                    end
                    default: begin
                        phase_next = PH_UP;
                    end
                endcase
            end
            ST_FLUSH: begin
                ram_we     = 1'b1;
                ram_waddr  = wr_addr_reg;
                ram_wdata  = blur_v;
                pend_next  = 1'b0;
                state_next = ST_COL;
            end
            ST_COL: begin
                if (col_go) begin
                    if (eff_prev < row_reg) begin
                        line_row_next = eff_prev + RW'(1);
                        end_row_next  = row_reg;
                    end else if (row_reg < eff_prev) begin
                        line_row_next = row_reg;
                        end_row_next  = eff_prev - RW'(1);
                    end else begin
                        line_row_next = row_reg;
                        end_row_next  = row_reg;
                    end
                    addr_next  = AW'(line_row_next) * AW'(WIDTH) + AW'(next_col_reg);
                    state_next = ST_LINE;
                end else begin
                    if (pos_reg == PW'(SAMPLES_PER_FRAME - 1)) begin
                        pos_next      = '0;
                        next_col_next = '0;
                    end else begin
                        pos_next = pos_reg + PW'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_LINE: begin
                ram_we    = 1'b1;
                ram_wdata = draw_colour;
                if (line_row_reg == end_row_reg) begin
                    prev_row_next = row_reg;
                    next_col_next = next_col_reg + NCW'(1);
                    state_next    = ST_COL;
                end else begin
                    line_row_next = line_row_reg + RW'(1);
                    addr_next     = addr_reg + AW'(WIDTH);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            phase_reg    <= PH_UP;
            addr_reg     <= '0;
            pend_reg     <= 1'b0;
            pos_reg      <= '0;
            next_col_reg <= '0;
            prev_row_reg <= '0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            addr_reg     <= addr_next;
            pend_reg     <= pend_next;
            pos_reg      <= pos_next;
            next_col_reg <= next_col_next;
            prev_row_reg <= prev_row_next;
        end
    end

    always_ff @(posedge aclk) begin
        b_row_reg    <= b_row_next;
        b_col_reg    <= b_col_next;
        wr_addr_reg  <= wr_addr_next;
        up_reg       <= up_next;
        right_reg    <= right_next;
        left_reg     <= left_next;
        lok_reg      <= lok_next;
        ok_reg       <= ok_next;
        rd_ok_reg    <= rd_ok_next;
        row_reg      <= row_next;
        line_row_reg <= line_row_next;
        end_row_reg  <= end_row_next;
    end
endmodule

/* src/fading_scope_frame_engine_unit.sv */
// Frame engine: a zero-bordered RGB frame in RAM, blurred per frame and drawn with a trace.
// Reset and a clear transaction each sweep the frame to zero, one pixel per cycle,
// with s_ready low. A read transaction's pixel is registered by the RAM, then loaded into
// the output register once that is free. A sample transaction visits each drawn column and
// writes its line pixels; the first sample of a frame first blurs the frame through the single
// read port of the frame RAM (three neighbour reads per pixel). One transaction at a time.
module fading_scope_frame_engine_unit #(
    parameter int WIDTH             = 64,
    parameter int HEIGHT            = 32,
    parameter int SAMPLES_PER_FRAME = 512
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       draw_colour_we,
    input  logic [fsfe_pkg::PIX_W-1:0] draw_colour_wdata,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_func,
    input  logic signed [15:0]         s_sample,
    input  logic [5:0]                 s_read_col,
    input  logic [4:0]                 s_read_row,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [fsfe_pkg::PIX_W-1:0] m_pixel_value
);
    import fsfe_pkg::*;

    localparam int NPIX = WIDTH * HEIGHT;
    localparam int AW   = $clog2(NPIX);

    logic [PIX_W-1:0] draw_colour_reg;
    logic             m_valid_reg, m_valid_next;
    logic [PIX_W-1:0] m_pixel_value_reg, m_pixel_value_next;
    logic             out_free;
    rsp_t             rsp;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [PIX_W-1:0] ram_wdata;
    logic             ram_re;
    logic [AW-1:0]    ram_raddr;
    logic [PIX_W-1:0] ram_rdata;

    assign out_free      = !m_valid_reg || m_ready;
    assign m_valid       = m_valid_reg;
    assign m_pixel_value = m_pixel_value_reg;

    fsfe_ctrl #(
        .WIDTH             (WIDTH),
        .HEIGHT            (HEIGHT),
        .SAMPLES_PER_FRAME (SAMPLES_PER_FRAME)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_sample    (s_sample),
        .s_read_col  (s_read_col),
        .s_read_row  (s_read_row),
        .draw_colour (draw_colour_reg),
        .out_free    (out_free),
        .rsp         (rsp),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata)
    );

    fsfe_ram #(
        .DATA_W (PIX_W),
        .DEPTH  (NPIX)
    ) u_frame_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        m_valid_next       = m_valid_reg;
        m_pixel_value_next = m_pixel_value_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (rsp.load) begin
            m_valid_next       = 1'b1;
            m_pixel_value_next = rsp.hit ? ram_rdata : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            draw_colour_reg <= RESET_COLOUR;
            m_valid_reg     <= 1'b0;
        end else begin
            if (draw_colour_we) begin
                draw_colour_reg <= draw_colour_wdata;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_pixel_value_reg <= m_pixel_value_next;
    end
endmodule
